@@ rtl/hrp_pkg.sv @@
// types, codes and character tables shared by the request parser
package hrp_pkg;

   // parse phases
   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_URI     = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_HEADER  = 3'd3;
   localparam logic [2:0] PH_BODY    = 3'd4;
   localparam logic [2:0] PH_DRAIN   = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_400 = 2'd1;
   localparam logic [1:0] STATUS_501 = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_URI     = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_BODY    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // method codes
   localparam logic [1:0] METHOD_NONE = 2'd0;
   localparam logic [1:0] METHOD_GET  = 2'd1;
   localparam logic [1:0] METHOD_PUT  = 2'd2;
   localparam logic [1:0] METHOD_HEAD = 2'd3;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   localparam logic [3:0] VERSION_LEN = 4'd8;
   localparam logic [3:0] KEY_LEN_LEN = 4'd14;
   localparam logic [3:0] KEY_ID_LEN  = 4'd9;

   localparam logic [32:0] VALUE_CAP = 33'h1_0000_0000;

   // result queue depth
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [2:0]  phase;
      logic [3:0]  tpos;
      logic [1:0]  meth;
      logic [1:0]  perr;
      logic [2:0]  uflags;
      logic [2:0]  kflags;
      logic        prev_cr;
      logic [32:0] acc;
      logic [31:0] len_val;
      logic [31:0] rid_val;
      logic [31:0] body_rem;
      logic        colon_pending;
      logic        digits_done;
   } parse_state_type;

   typedef struct packed {
      parse_state_type st;
      logic            emit;
   } feed_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [1:0]  method;
      logic [31:0] body_length;
      logic [31:0] request_number;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } push_type;

   function automatic parse_state_type clear_state();
      parse_state_type s;
      s = '0;
      s.phase  = PH_METHOD;
      s.kflags = 3'b011;
      return s;
   endfunction

   function automatic logic [3:0] bump(logic [3:0] p);
      return (p == 4'd15) ? p : p + 4'd1;
   endfunction

   function automatic logic [3:0] method_len(logic [1:0] m);
      case (m)
         METHOD_GET:  return 4'd3;
         METHOD_PUT:  return 4'd3;
         METHOD_HEAD: return 4'd4;
         default:     return 4'd0;
      endcase
   endfunction

   function automatic logic [7:0] method_char(logic [1:0] m, logic [3:0] p);
      logic [7:0] c;
      c = 8'h00;
      case (m)
         METHOD_GET: begin
            case (p)
               4'd0:    c = "G";
               4'd1:    c = "E";
               4'd2:    c = "T";
               default: c = 8'h00;
            endcase
         end
         METHOD_PUT: begin
            case (p)
               4'd0:    c = "P";
               4'd1:    c = "U";
               4'd2:    c = "T";
               default: c = 8'h00;
            endcase
         end
         METHOD_HEAD: begin
            case (p)
               4'd0:    c = "H";
               4'd1:    c = "E";
               4'd2:    c = "A";
               4'd3:    c = "D";
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] version_char(logic [3:0] p);
      case (p)
         4'd0:    return "H";
         4'd1:    return "T";
         4'd2:    return "T";
         4'd3:    return "P";
         4'd4:    return "/";
         4'd5:    return "1";
         4'd6:    return ".";
         4'd7:    return "1";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] key_len_char(logic [3:0] p);
      case (p)
         4'd0:    return "C";
         4'd1:    return "o";
         4'd2:    return "n";
         4'd3:    return "t";
         4'd4:    return "e";
         4'd5:    return "n";
         4'd6:    return "t";
         4'd7:    return "-";
         4'd8:    return "L";
         4'd9:    return "e";
         4'd10:   return "n";
         4'd11:   return "g";
         4'd12:   return "t";
         4'd13:   return "h";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] key_id_char(logic [3:0] p);
      case (p)
         4'd0:    return "R";
         4'd1:    return "e";
         4'd2:    return "q";
         4'd3:    return "u";
         4'd4:    return "e";
         4'd5:    return "s";
         4'd6:    return "t";
         4'd7:    return "I";
         4'd8:    return "D";
         default: return 8'h00;
      endcase
   endfunction

   function automatic parse_state_type set_pending(parse_state_type s, logic [1:0] code);
      parse_state_type r;
      r = s;
      if (r.perr == STATUS_OK) begin
         r.perr = code;
      end
      return r;
   endfunction

   function automatic parse_state_type key_step(parse_state_type s, logic [7:0] c);
      parse_state_type r;
      r = s;
      if (s.tpos >= KEY_LEN_LEN || c != key_len_char(s.tpos)) begin
         r.kflags[0] = 1'b0;
      end
      if (s.tpos >= KEY_ID_LEN || c != key_id_char(s.tpos)) begin
         r.kflags[1] = 1'b0;
      end
      r.tpos = bump(s.tpos);
      return r;
   endfunction

   // one byte of the request line or of a header line
   function automatic feed_type feed(parse_state_type s, logic [7:0] c);
      feed_type   r;
      logic [36:0] prod;
      r.st   = s;
      r.emit = 1'b0;
      prod   = '0;
      case (s.phase)
         PH_METHOD: begin
            if (c == CHAR_SPACE) begin
               if (s.meth == METHOD_NONE || s.tpos != method_len(s.meth)) begin
                  r.st = set_pending(r.st, STATUS_501);
               end
               r.st.phase = PH_URI;
               r.st.tpos  = 4'd0;
            end else begin
               if (s.tpos == 4'd0) begin
                  r.st.meth = (c == "G") ? METHOD_GET :
                              (c == "P") ? METHOD_PUT :
                              (c == "H") ? METHOD_HEAD : METHOD_NONE;
               end else if (s.meth != METHOD_NONE &&
                            (s.tpos >= method_len(s.meth) ||
                             c != method_char(s.meth, s.tpos))) begin
                  r.st.meth = METHOD_NONE;
               end
               r.st.tpos = bump(s.tpos);
            end
         end
         PH_URI: begin
            if (c == CHAR_SPACE) begin
               if (!s.uflags[2]) begin
                  r.st = set_pending(r.st, STATUS_400);
               end
               r.st.phase = PH_VERSION;
               r.st.tpos  = 4'd0;
            end else if (!s.uflags[0]) begin
               r.st.uflags[0] = 1'b1;
               if (c == CHAR_SLASH) begin
                  r.st.uflags[1] = 1'b1;
               end else begin
                  r.st = set_pending(r.st, STATUS_400);
               end
            end else begin
               r.st.uflags[2] = 1'b1;
               if (c == CHAR_SLASH || c == CHAR_BSLASH) begin
                  r.st = set_pending(r.st, STATUS_400);
               end else if (s.perr == STATUS_OK) begin
                  r.emit = 1'b1;
               end
            end
         end
         PH_VERSION: begin
            if (s.tpos >= VERSION_LEN || c != version_char(s.tpos)) begin
               r.st = set_pending(r.st, STATUS_400);
            end
            r.st.tpos = bump(s.tpos);
         end
         PH_HEADER: begin
            if (!s.kflags[2]) begin
               if (s.colon_pending && c == CHAR_SPACE) begin
                  // ": " separator seen, value starts
                  r.st.colon_pending = 1'b0;
                  r.st.kflags[2]     = 1'b1;
                  r.st.acc           = '0;
                  r.st.digits_done   = 1'b0;
               end else begin
                  if (s.colon_pending) begin
                     r.st.colon_pending = 1'b0;
                     r.st = key_step(r.st, CHAR_COLON);
                  end
                  if (c == CHAR_COLON) begin
                     r.st.colon_pending = 1'b1;
                  end else begin
                     r.st = key_step(r.st, c);
                  end
               end
            end else if (!s.digits_done) begin
               if (c >= "0" && c <= "9") begin
                  prod = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} +
                         {29'd0, c - 8'h30};
                  r.st.acc = (prod > {4'd0, VALUE_CAP}) ? VALUE_CAP : prod[32:0];
               end else begin
                  r.st.digits_done = 1'b1;
               end
            end
         end
         default: r.st = s;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/hrp_if.sv @@
// request and result channel interfaces
interface hrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] request_byte;
   logic       stream_end;
   modport source(output valid, request_byte, stream_end, input ready);
   modport sink(input valid, request_byte, stream_end, output ready);
endinterface

interface hrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [1:0]  status;
   logic [1:0]  method;
   logic [31:0] body_length;
   logic [31:0] request_number;
   logic        last;
   modport source(output valid, kind, data_byte, status, method, body_length,
                  request_number, last, input ready);
   modport sink(input valid, kind, data_byte, status, method, body_length,
                request_number, last, output ready);
endinterface

@@ rtl/hrp_front.sv @@
// front end: takes request bytes, runs the parse state and produces result items
module hrp_front
   import hrp_pkg::*;
#(
   parameter int HEADER_LIMIT = 2048
) (
   input  logic      clock,
   input  logic      reset,
   hrp_req_if.sink   req_ch,
   input  logic      queue_full,
   output push_type  push
);

   localparam int CountWidth = $clog2(HEADER_LIMIT + 2);
   localparam logic [CountWidth-1:0] Limit = CountWidth'(HEADER_LIMIT);

   parse_state_type        state_ff, state_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   accept;
   logic [7:0]             c;
   parse_state_type        s;
   feed_type               fr;
   logic [31:0]            rem;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign c            = req_ch.request_byte;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      push       = '0;
      s          = state_ff;
      fr         = '0;
      rem        = '0;
      if (req_ch.stream_end) begin
         state_in = clear_state();
         count_in = '0;
         if (!(state_ff.phase == PH_DRAIN ||
               (state_ff.phase == PH_METHOD && count_ff == '0))) begin
            push.valid       = 1'b1;
            push.item.kind   = KIND_ERROR;
            push.item.status = STATUS_400;
            push.item.last   = 1'b1;
         end
      end else if (state_ff.phase == PH_DRAIN) begin
         state_in = state_ff;
      end else if (state_ff.phase == PH_BODY) begin
         rem = (state_ff.body_rem != '0) ? state_ff.body_rem - 32'd1 : state_ff.body_rem;
         push.valid          = 1'b1;
         push.item.kind      = KIND_BODY;
         push.item.data_byte = c;
         push.item.last      = (rem == '0);
         if (rem == '0) begin
            state_in = clear_state();
            count_in = '0;
         end else begin
            state_in.body_rem = rem;
         end
      end else begin
         count_in = (count_ff <= Limit) ? count_ff + 1'b1 : count_ff;
         if (count_in > Limit) begin
            // header section too long
            push.valid       = 1'b1;
            push.item.kind   = KIND_ERROR;
            push.item.status = STATUS_400;
            push.item.last   = 1'b1;
            state_in.phase   = PH_DRAIN;
         end else if (state_ff.prev_cr && c == CHAR_LF) begin
            state_in.prev_cr = 1'b0;
            if (state_ff.phase == PH_HEADER) begin
               if (!state_ff.kflags[2] && state_ff.tpos == 4'd0 &&
                   !state_ff.colon_pending) begin
                  // blank line ends the headers
                  push.valid               = 1'b1;
                  push.item.kind           = KIND_SUMMARY;
                  push.item.method         = state_ff.meth;
                  push.item.request_number = state_ff.rid_val;
                  if (state_ff.len_val == '0) begin
                     push.item.last = 1'b1;
                     state_in       = clear_state();
                     count_in       = '0;
                  end else begin
                     push.item.body_length = state_ff.len_val;
                     state_in.body_rem     = state_ff.len_val;
                     state_in.phase        = PH_BODY;
                  end
               end else if (!state_ff.kflags[2] ||
                            (state_ff.acc[32] &&
                             ((state_ff.kflags[0] && state_ff.tpos == KEY_LEN_LEN) ||
                              (state_ff.kflags[1] && state_ff.tpos == KEY_ID_LEN)))) begin
                  push.valid       = 1'b1;
                  push.item.kind   = KIND_ERROR;
                  push.item.status = STATUS_400;
                  push.item.last   = 1'b1;
                  state_in.phase   = PH_DRAIN;
               end else begin
                  if (state_ff.kflags[0] && state_ff.tpos == KEY_LEN_LEN) begin
                     state_in.len_val = state_ff.acc[31:0];
                  end else if (state_ff.kflags[1] && state_ff.tpos == KEY_ID_LEN) begin
                     state_in.rid_val = state_ff.acc[31:0];
                  end
                  state_in.tpos          = 4'd0;
                  state_in.kflags        = 3'b011;
                  state_in.colon_pending = 1'b0;
                  state_in.digits_done   = 1'b0;
                  state_in.acc           = '0;
               end
            end else begin
               // end of request line
               s = state_ff;
               if (state_ff.phase == PH_VERSION && state_ff.tpos != VERSION_LEN) begin
                  s = set_pending(s, STATUS_400);
               end
               if (count_in >= Limit || state_ff.phase == PH_METHOD) begin
                  push.item.status = STATUS_400;
               end else if (state_ff.phase == PH_URI) begin
                  push.item.status = (s.perr != STATUS_OK) ? s.perr : STATUS_400;
               end else begin
                  push.item.status = s.perr;
               end
               if (push.item.status != STATUS_OK) begin
                  push.valid     = 1'b1;
                  push.item.kind = KIND_ERROR;
                  push.item.last = 1'b1;
                  state_in.phase = PH_DRAIN;
               end else begin
                  state_in.phase         = PH_HEADER;
                  state_in.tpos          = 4'd0;
                  state_in.kflags        = 3'b011;
                  state_in.colon_pending = 1'b0;
                  state_in.digits_done   = 1'b0;
                  state_in.acc           = '0;
               end
            end
         end else begin
            s         = state_ff;
            s.prev_cr = 1'b0;
            // a lone cr counts as an ordinary byte
            if (state_ff.prev_cr && state_ff.phase != PH_URI) begin
               fr = feed(s, CHAR_CR);
               s  = fr.st;
            end
            if (c == CHAR_CR && state_ff.phase != PH_URI) begin
               s.prev_cr = 1'b1;
               state_in  = s;
            end else begin
               fr               = feed(s, c);
               state_in         = fr.st;
               state_in.prev_cr = (c == CHAR_CR);
               if (fr.emit) begin
                  push.valid          = 1'b1;
                  push.item.kind      = KIND_URI;
                  push.item.data_byte = c;
               end
            end
         end
      end
      if (!accept) begin
         push.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clear_state();
         count_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/hrp_queue.sv @@
// back end: short result queue that drives the result channel
module hrp_queue
   import hrp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     queue_full,
   hrp_rsp_if.source rsp_ch
);

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type          store_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  pop;
   rsp_item_type          head;

   assign queue_full = (count_ff == CntWidth'(QUEUE_DEPTH));
   assign pop        = rsp_ch.valid && rsp_ch.ready;
   assign head       = store_ff[rd_ptr_ff];

   assign rsp_ch.valid          = (count_ff != '0);
   assign rsp_ch.kind           = head.kind;
   assign rsp_ch.data_byte      = head.data_byte;
   assign rsp_ch.status         = head.status;
   assign rsp_ch.method         = head.method;
   assign rsp_ch.body_length    = head.body_length;
   assign rsp_ch.request_number = head.request_number;
   assign rsp_ch.last           = head.last;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CntWidth'(push.valid) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/http_request_header_parser.sv @@
// top level of the http/1.1 request parser
// takes one request byte per item and one item per cycle; each byte causes at
// most one result item (uri byte, header summary, body byte or error status)
// computed in the same cycle by the front end's combinational parse step, and
// results wait in a four-entry queue so the request side keeps flowing while
// the result side stalls; the request side stalls only when that queue is full;
// the method must be GET, PUT or HEAD (else 501), the version HTTP/1.1, and the
// header section may hold up to HEADER_LIMIT bytes; Content-Length and
// RequestID are decoded, and after the summary exactly Content-Length body
// bytes follow; after an error, bytes are dropped until stream_end
module http_request_header_parser
   import hrp_pkg::*;
#(
   parameter int HEADER_LIMIT = 2048
) (
   input  logic      clock,
   input  logic      reset,
   hrp_req_if.sink   req_ch,
   hrp_rsp_if.source rsp_ch
);

   // item handoff from the parse step to the result queue
   push_type push;
   logic     queue_full;

   // parse step: classifies each byte and updates request state
   hrp_front #(
      .HEADER_LIMIT(HEADER_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   // result queue: decouples result stalls from byte intake
   hrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_full (queue_full),
      .rsp_ch     (rsp_ch)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the http request parser: directed table plus random requests, checked by a predictor
module tb_top;
   import hrp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_LIMIT = 2048;
   localparam int RANDOM_ITEMS = 800;

   logic clock;
   logic reset;

   hrp_req_if req_ch ();
   hrp_rsp_if rsp_ch ();

   http_request_header_parser #(.HEADER_LIMIT(HDR_LIMIT)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // result fields in port order
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [1:0]  method;
      logic [31:0] body_length;
      logic [31:0] request_number;
      logic        last;
   } parse_result_type;

   // one row of the directed table; has_fixed marks a hand-written expectation
   typedef struct {
      logic [7:0]       byte_val;
      logic             close;
      logic             has_fixed;
      logic             fixed_some;
      parse_result_type fixed_res;
   } stim_row_type;

   // predictor state
   logic [2:0]  p_phase;
   int unsigned p_hdr_count;
   logic [3:0]  p_pos;
   logic [1:0]  p_meth;
   logic [1:0]  p_err;
   logic [2:0]  p_uri;
   logic [2:0]  p_keys;
   logic        p_cr;
   logic [32:0] p_acc;
   logic [31:0] p_len;
   logic [31:0] p_rid;
   logic [31:0] p_body_left;
   logic        p_colon;
   logic        p_digits_done;

   parse_result_type expected_results[$];
   int          error_count;
   int          items_sent;
   logic        idle_enable;
   logic        timed_out;

   string meth_name[4] = '{"", "GET", "PUT", "HEAD"};
   string version_text = "HTTP/1.1";
   string len_key = "Content-Length";
   string id_key = "RequestID";

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // overall limit: ~3200 items with the longest idle gaps on both sides, many times over
   initial begin
      timed_out = 1'b0;
      #4_000_000;
      timed_out = 1'b1;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic parse_result_type make_result(logic [1:0] k, logic [7:0] d,
                                                    logic [1:0] s, logic [1:0] m,
                                                    logic [31:0] bl, logic [31:0] rn,
                                                    logic l);
      parse_result_type r;
      r.kind = k; r.data_byte = d; r.status = s; r.method = m;
      r.body_length = bl; r.request_number = rn; r.last = l;
      return r;
   endfunction

   function automatic parse_result_type error_result(logic [1:0] code);
      return make_result(KIND_ERROR, 8'h00, code, METHOD_NONE, 32'd0, 32'd0, 1'b1);
   endfunction

   task automatic restart_request();
      p_phase = PH_METHOD; p_hdr_count = 0; p_pos = 4'd0; p_meth = METHOD_NONE;
      p_err = STATUS_OK; p_uri = 3'd0; p_keys = 3'b011; p_cr = 1'b0; p_acc = '0;
      p_len = '0; p_rid = '0; p_body_left = '0; p_colon = 1'b0; p_digits_done = 1'b0;
   endtask

   function automatic logic [3:0] step_pos(logic [3:0] p);
      return (p == 4'd15) ? p : p + 4'd1;
   endfunction

   task automatic note_error(logic [1:0] code);
      if (p_err == STATUS_OK) p_err = code;
   endtask

   task automatic reject(logic [1:0] code, output logic some, output parse_result_type r);
      r = error_result(code);
      some = 1'b1;
      p_phase = PH_DRAIN;
   endtask

   task automatic match_key_char(logic [7:0] c);
      if (p_pos >= 14 || c != len_key[p_pos]) p_keys[0] = 1'b0;
      if (p_pos >= 9 || c != id_key[p_pos]) p_keys[1] = 1'b0;
      p_pos = step_pos(p_pos);
   endtask

   // one byte of request line or header line
   task automatic parse_char(logic [7:0] c, output logic some, output parse_result_type r);
      some = 1'b0;
      r = error_result(STATUS_OK);
      case (p_phase)
         PH_METHOD: begin
            if (c == CHAR_SPACE) begin
               if (p_meth == METHOD_NONE || p_pos != meth_name[p_meth].len())
                  note_error(STATUS_501);
               p_phase = PH_URI;
               p_pos = 4'd0;
            end else begin
               if (p_pos == 0)
                  p_meth = (c == "G") ? METHOD_GET : (c == "P") ? METHOD_PUT :
                           (c == "H") ? METHOD_HEAD : METHOD_NONE;
               else if (p_meth != METHOD_NONE &&
                        (p_pos >= meth_name[p_meth].len() || c != meth_name[p_meth][p_pos]))
                  p_meth = METHOD_NONE;
               p_pos = step_pos(p_pos);
            end
         end
         PH_URI: begin
            if (c == CHAR_SPACE) begin
               if (!p_uri[2]) note_error(STATUS_400);
               p_phase = PH_VERSION;
               p_pos = 4'd0;
            end else if (!p_uri[0]) begin
               p_uri[0] = 1'b1;
               if (c == CHAR_SLASH) p_uri[1] = 1'b1;
               else note_error(STATUS_400);
            end else begin
               p_uri[2] = 1'b1;
               if (c == CHAR_SLASH || c == CHAR_BSLASH) begin
                  note_error(STATUS_400);
               end else if (p_err == STATUS_OK) begin
                  some = 1'b1;
                  r = make_result(KIND_URI, c, STATUS_OK, METHOD_NONE, 32'd0, 32'd0, 1'b0);
               end
            end
         end
         PH_VERSION: begin
            if (p_pos >= 8 || c != version_text[p_pos]) note_error(STATUS_400);
            p_pos = step_pos(p_pos);
         end
         default: begin
            if (!p_keys[2]) begin
               if (p_colon && c == CHAR_SPACE) begin
                  // separator complete, value follows
                  p_colon = 1'b0;
                  p_keys[2] = 1'b1;
                  p_acc = '0;
                  p_digits_done = 1'b0;
               end else begin
                  if (p_colon) begin
                     p_colon = 1'b0;
                     match_key_char(CHAR_COLON);
                  end
                  if (c == CHAR_COLON) p_colon = 1'b1;
                  else match_key_char(c);
               end
            end else if (!p_digits_done) begin
               if (c >= "0" && c <= "9") begin
                  p_acc = (p_acc > 33'd429496729) ? 33'h1_0000_0000 :
                          p_acc * 10 + (c - "0");
                  if (p_acc > 33'h1_0000_0000) p_acc = 33'h1_0000_0000;
               end else begin
                  p_digits_done = 1'b1;
               end
            end
         end
      endcase
   endtask

   // predicted result of one accepted byte or stream end
   task automatic predict_parse(logic [7:0] c, logic close,
                                output logic some, output parse_result_type r);
      logic dummy;
      parse_result_type scratch;
      some = 1'b0;
      r = error_result(STATUS_OK);
      if (close) begin
         if (!(p_phase == PH_DRAIN || (p_phase == PH_METHOD && p_hdr_count == 0))) begin
            some = 1'b1;
            r = error_result(STATUS_400);
         end
         restart_request();
         return;
      end
      if (p_phase == PH_DRAIN) return;
      if (p_phase == PH_BODY) begin
         if (p_body_left > 0) p_body_left--;
         some = 1'b1;
         r = make_result(KIND_BODY, c, STATUS_OK, METHOD_NONE, 32'd0, 32'd0,
                         p_body_left == 0);
         if (p_body_left == 0) restart_request();
         return;
      end
      if (p_hdr_count <= HDR_LIMIT) p_hdr_count++;
      if (p_hdr_count > HDR_LIMIT) begin
         reject(STATUS_400, some, r);
         return;
      end
      if (p_cr && c == CHAR_LF) begin
         p_cr = 1'b0;
         if (p_phase == PH_HEADER) begin
            // end of a header line, or the blank line
            if (!p_keys[2] && p_pos == 0 && !p_colon) begin
               some = 1'b1;
               r = make_result(KIND_SUMMARY, 8'h00, STATUS_OK, p_meth, p_len, p_rid,
                               p_len == 0);
               if (p_len == 0) restart_request();
               else begin
                  p_body_left = p_len;
                  p_phase = PH_BODY;
               end
               return;
            end
            if (!p_keys[2]) begin
               reject(STATUS_400, some, r);
               return;
            end
            if (p_keys[0] && p_pos == 14) begin
               if (p_acc[32]) begin
                  reject(STATUS_400, some, r);
                  return;
               end
               p_len = p_acc[31:0];
            end else if (p_keys[1] && p_pos == 9) begin
               if (p_acc[32]) begin
                  reject(STATUS_400, some, r);
                  return;
               end
               p_rid = p_acc[31:0];
            end
         end else begin
            // end of the request line
            if (p_hdr_count >= HDR_LIMIT || p_phase == PH_METHOD) begin
               reject(STATUS_400, some, r);
               return;
            end
            if (p_phase == PH_URI) begin
               reject(p_err != STATUS_OK ? p_err : STATUS_400, some, r);
               return;
            end
            if (p_pos != 8) note_error(STATUS_400);
            if (p_err != STATUS_OK) begin
               reject(p_err, some, r);
               return;
            end
            p_phase = PH_HEADER;
         end
         p_pos = 4'd0; p_keys = 3'b011; p_colon = 1'b0; p_digits_done = 1'b0; p_acc = '0;
         return;
      end
      if (p_cr) begin
         // lone cr is an ordinary byte (already fed inside the uri)
         p_cr = 1'b0;
         if (p_phase != PH_URI) parse_char(CHAR_CR, dummy, scratch);
      end
      if (c == CHAR_CR) begin
         p_cr = 1'b1;
         if (p_phase == PH_URI) parse_char(c, some, r);
         return;
      end
      parse_char(c, some, r);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // result side: random stalls, checks each accepted item against the oldest expectation
   initial begin
      parse_result_type want;
      int stall;
      rsp_ch.ready = 1'b0;
      error_count = 0;
      @(posedge clock iff !reset);
      forever begin
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 18);
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item kind", rsp_ch.kind, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.kind !== want.kind) report_mismatch("kind", rsp_ch.kind, want.kind);
               if (rsp_ch.data_byte !== want.data_byte)
                  report_mismatch("data_byte", rsp_ch.data_byte, want.data_byte);
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", rsp_ch.status, want.status);
               if (rsp_ch.method !== want.method)
                  report_mismatch("method", rsp_ch.method, want.method);
               if (rsp_ch.body_length !== want.body_length)
                  report_mismatch("body_length", rsp_ch.body_length, want.body_length);
               if (rsp_ch.request_number !== want.request_number)
                  report_mismatch("request_number", rsp_ch.request_number,
                                  want.request_number);
               if (rsp_ch.last !== want.last) report_mismatch("last", rsp_ch.last, want.last);
            end
         end
      end
   end

   // send one item, predict its result when accepted
   task automatic send_byte(logic [7:0] c, logic close, logic has_fixed, logic fixed_some,
                            parse_result_type fixed_res);
      logic some;
      parse_result_type r;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.request_byte <= c;
      req_ch.stream_end <= close;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      predict_parse(c, close, some, r);
      if (has_fixed && (some !== fixed_some || (some && r != fixed_res)))
         report_mismatch("predictor vs table kind", r.kind, fixed_res.kind);
      if (some) expected_results.push_back(r);
   endtask

   task automatic send_text(string s);
      parse_result_type none;
      none = error_result(STATUS_OK);
      foreach (s[i]) send_byte(s[i], 1'b0, 1'b0, 1'b0, none);
   endtask

   task automatic send_random_byte();
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, error_result(STATUS_OK));
   endtask

   task automatic send_close();
      send_byte(8'h00, 1'b1, 1'b0, 1'b0, error_result(STATUS_OK));
   endtask

   // random request, mostly well formed with random content
   task automatic send_random_request();
      string uri, text;
      int n, blen, pick;
      pick = $urandom_range(0, 9);
      uri = "/";
      n = $urandom_range(1, 6);
      repeat (n) uri = {uri, string'(8'($urandom_range(8'h21, 8'h7e) == 8'h2f ?
                                           8'h61 : $urandom_range(8'h21, 8'h7e)))};
      blen = $urandom_range(0, 5);
      case ($urandom_range(0, 2))
         0: text = "GET ";
         1: text = "PUT ";
         default: text = "HEAD ";
      endcase
      if (pick == 0) text = (pick % 2) ? "POST " : "GEX ";
      text = {text, uri, " HTTP/1.1\r\n"};
      if ($urandom_range(0, 1)) text = {text, $sformatf("RequestID: %0d\r\n", $urandom)};
      if ($urandom_range(0, 3) == 0) text = {text, "X-Any: a:b\r\n"};
      if (blen != 0) text = {text, $sformatf("Content-Length: %0d\r\n", blen)};
      if (pick == 1) text = {text, "Content-Length: 99999999999\r\n"};
      if (pick == 2) text = {text, "BadLine\r\n"};
      text = {text, "\r\n"};
      if (pick == 3) begin
         // broken mid-way: truncate and close the stream
         send_text(text.substr(0, $urandom_range(0, text.len() - 1)));
         send_close();
         return;
      end
      send_text(text);
      repeat (blen) send_random_byte();
      if (pick == 4) begin
         repeat ($urandom_range(1, 8)) send_random_byte();
         send_close();
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // directed stimulus table
   stim_row_type dir_rows[$];

   task automatic add_row(logic [7:0] c, logic close, logic fixed, logic some,
                          parse_result_type r);
      stim_row_type row;
      row.byte_val = c; row.close = close; row.has_fixed = fixed;
      row.fixed_some = some; row.fixed_res = r;
      dir_rows.push_back(row);
   endtask

   task automatic add_text(string s);
      foreach (s[i]) add_row(s[i], 1'b0, 1'b0, 1'b0, error_result(STATUS_OK));
   endtask

   initial begin
      int sent;
      string big;
      req_ch.valid = 1'b0;
      req_ch.request_byte = 8'h00;
      req_ch.stream_end = 1'b0;
      idle_enable = 1'b1;
      items_sent = 0;
      restart_request();
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // close right after reset: no result
      add_row(8'hff, 1'b1, 1'b1, 1'b0, error_result(STATUS_OK));
      // bad method reported at the line end as 501
      add_text("PATCH /a HTTP/1.1\r");
      add_row(CHAR_LF, 1'b0, 1'b1, 1'b1, error_result(STATUS_501));
      add_row(8'hff, 1'b0, 1'b1, 1'b0, error_result(STATUS_OK));
      add_row(8'h00, 1'b1, 1'b1, 1'b0, error_result(STATUS_OK));
      foreach (dir_rows[i])
         send_byte(dir_rows[i].byte_val, dir_rows[i].close, dir_rows[i].has_fixed,
                   dir_rows[i].fixed_some, dir_rows[i].fixed_res);
      // head with body, cr in uri, missing uri, max values, nul bytes
      send_text("HEAD /x HTTP/1.1\r\nContent-Length: 2\r\nRequestID: 4294967295\r\n\r\n");
      send_byte(8'h00, 1'b0, 1'b0, 1'b0, error_result(STATUS_OK));
      send_byte(8'hff, 1'b0, 1'b0, 1'b0, error_result(STATUS_OK));
      send_text("GET /a\r\n");
      send_close();
      send_text("PUT / HTTP/1.1\r\n");
      send_close();
      send_text("GET /a\\ HTTP/1.0\r\n");
      send_close();
      send_text("GET /q HTTP/1.1\r\nRequestID: 4294967296\r\n");
      send_close();
      // body cut by stream end
      send_text("PUT /b HTTP/1.1\r\nContent-Length: 3\r\n\r\nz");
      send_close();
      // oversize header section
      big = "GET /z HTTP/1.1\r\nX: ";
      while (big.len() < HDR_LIMIT + 4) big = {big, "aaaaaaaaaaaaaaaa"};
      send_text(big);
      send_close();

      // pause until everything has come out
      wait_drained();

      // random part counted in accepted items
      sent = items_sent;
      while (items_sent - sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            send_random_byte();
            if ($urandom_range(0, 3) == 0) send_close();
         end else begin
            send_random_request();
         end
         // last part of the run without idling
         if (items_sent - sent > RANDOM_ITEMS * 3 / 4) idle_enable = 1'b0;
      end
      send_close();
      wait_drained();
      if (error_count == 0 && !timed_out) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
